@@ hdl/dsu_pkg.sv @@
`default_nettype none

package dsu_pkg;

    // Fixed widths of the channel fields.
    localparam int OP_W       = 3;
    localparam int ELEM_W     = 9;
    localparam int COUNT_W    = 10;
    localparam int SIZE_OUT_W = 10;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd0;
    localparam logic [OP_W-1:0] OP_FIND  = 3'd1;
    localparam logic [OP_W-1:0] OP_UNITE = 3'd2;
    localparam logic [OP_W-1:0] OP_SAME  = 3'd3;
    localparam logic [OP_W-1:0] OP_SIZE  = 3'd4;

    // Element count after reset.
    localparam logic [COUNT_W-1:0] COUNT_RESET = 10'd512;

    // Write strobes from the sequencer to the table memories.
    typedef struct packed {
        logic parent_we;
        logic size_we;
    } tbl_ctl_t;

endpackage

`default_nettype wire

@@ hdl/dsu_if.sv @@
`default_nettype none

// Command channel: one operation per transfer.
interface dsu_in_if import dsu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [ELEM_W-1:0] element_a;
    logic [ELEM_W-1:0] element_b;

    modport source (output valid, output operation, output element_a, output element_b,
                    input ready);
    modport sink   (input valid, input operation, input element_a, input element_b,
                    output ready);
endinterface

// Result channel: one result per command.
interface dsu_out_if import dsu_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [ELEM_W-1:0]     root_a;
    logic [ELEM_W-1:0]     root_b;
    logic                  same_set;
    logic                  merged;
    logic [SIZE_OUT_W-1:0] set_size;
    logic                  index_error;

    modport source (output valid, output root_a, output root_b, output same_set,
                    output merged, output set_size, output index_error, input ready);
    modport sink   (input valid, input root_a, input root_b, input same_set,
                    input merged, input set_size, input index_error, output ready);
endinterface

// Configuration write channel for the element count.
interface dsu_cfg_if import dsu_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/dsu_table.sv @@
`default_nettype none

module dsu_table import dsu_pkg::*; #(
    parameter int DEPTH  = 512,
    parameter int IDX_W  = 9,
    parameter int SIZE_W = 10
) (
    input  wire logic              clk,
    input  wire tbl_ctl_t          tbl_ctl,
    input  wire logic [IDX_W-1:0]  p_raddr,
    input  wire logic [IDX_W-1:0]  p_waddr,
    input  wire logic [IDX_W-1:0]  p_wdata,
    output logic      [IDX_W-1:0]  p_rdata,
    input  wire logic [IDX_W-1:0]  s_raddr,
    input  wire logic [IDX_W-1:0]  s_waddr,
    input  wire logic [SIZE_W-1:0] s_wdata,
    output logic      [SIZE_W-1:0] s_rdata
);

    logic [IDX_W-1:0]  parent_mem [DEPTH];
    logic [SIZE_W-1:0] size_mem   [DEPTH];

    // Parent memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (tbl_ctl.parent_we)
        begin
            parent_mem[p_waddr] <= p_wdata;
        end
        p_rdata <= parent_mem[p_raddr];
    end

    // Size memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (tbl_ctl.size_we)
        begin
            size_mem[s_waddr] <= s_wdata;
        end
        s_rdata <= size_mem[s_raddr];
    end

endmodule

`default_nettype wire

@@ hdl/dsu_ctrl.sv @@
`default_nettype none

module dsu_ctrl import dsu_pkg::*; #(
    parameter int DEPTH  = 512,
    parameter int IDX_W  = 9,
    parameter int SIZE_W = 10
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    dsu_in_if.sink                  req,
    dsu_out_if.source               rsp,
    input  wire logic [COUNT_W-1:0] element_count,
    output tbl_ctl_t                tbl_ctl,
    output logic      [IDX_W-1:0]   p_raddr,
    output logic      [IDX_W-1:0]   p_waddr,
    output logic      [IDX_W-1:0]   p_wdata,
    input  wire logic [IDX_W-1:0]   p_rdata,
    output logic      [IDX_W-1:0]   s_raddr,
    output logic      [IDX_W-1:0]   s_waddr,
    output logic      [SIZE_W-1:0]  s_wdata,
    input  wire logic [SIZE_W-1:0]  s_rdata
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    typedef enum logic [9:0] {
        ST_SWEEP  = 10'b00_0000_0001,
        ST_IDLE   = 10'b00_0000_0010,
        ST_WISSUE = 10'b00_0000_0100,
        ST_WALK   = 10'b00_0000_1000,
        ST_CISSUE = 10'b00_0001_0000,
        ST_COMP   = 10'b00_0010_0000,
        ST_SZA    = 10'b00_0100_0000,
        ST_SZB    = 10'b00_1000_0000,
        ST_SZC    = 10'b01_0000_0000,
        ST_DONE   = 10'b10_0000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   sweep_reg, sweep_next;
    logic               sweep_reply_reg, sweep_reply_next;
    logic               phase_b_reg, phase_b_next;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [IDX_W-1:0]   start_reg, start_next;
    logic [IDX_W-1:0]   elem_b_reg, elem_b_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic [IDX_W-1:0]   root_reg, root_next;
    logic [IDX_W-1:0]   ra_reg, ra_next;
    logic [IDX_W-1:0]   rb_reg, rb_next;
    logic [SIZE_W-1:0]  size_a_reg, size_a_next;
    logic [SIZE_W-1:0]  sz_reg, sz_next;
    logic               same_reg, same_next;
    logic               merged_reg, merged_next;
    logic               err_reg, err_next;

    logic                  rsp_valid_reg, rsp_valid_next;
    logic [ELEM_W-1:0]     rsp_root_a_reg;
    logic [ELEM_W-1:0]     rsp_root_b_reg;
    logic                  rsp_same_reg;
    logic                  rsp_merged_reg;
    logic [SIZE_OUT_W-1:0] rsp_size_reg;
    logic                  rsp_err_reg;

    logic              acc;
    logic              a_bad;
    logic              b_bad;
    logic              needs_b;
    logic              load_out;
    logic [IDX_W-1:0]  cmp_x;
    logic [IDX_W-1:0]  cmp_y;
    logic              eq;
    logic [SIZE_W-1:0] sum;
    logic              big_is_b;

    // Command handshake and index range checks against min(count, depth).
    assign req.ready = (state_reg == ST_IDLE);
    assign acc       = req.valid && req.ready;
    assign a_bad     = ({1'b0, req.element_a} >= element_count)
                    || (32'(req.element_a) >= 32'(DEPTH));
    assign b_bad     = ({1'b0, req.element_b} >= element_count)
                    || (32'(req.element_b) >= 32'(DEPTH));
    assign needs_b   = (op_reg == OP_UNITE) || (op_reg == OP_SAME);

    // Shared equality unit: root test on the walk, end of path on the
    // rewrite pass, and the same-set test on the two roots.
    always_comb
    begin
        unique case (state_reg)
            ST_WALK:
            begin
                cmp_x = p_rdata;
                cmp_y = cur_reg;
            end
            ST_COMP:
            begin
                cmp_x = cur_reg;
                cmp_y = root_reg;
            end
            default:
            begin
                cmp_x = ra_reg;
                cmp_y = rb_reg;
            end
        endcase
    end
    assign eq = (cmp_x == cmp_y);

    // Size merge arithmetic; the sum never exceeds the depth.
    assign sum      = size_a_reg + s_rdata;
    assign big_is_b = (size_a_reg < s_rdata);

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        sweep_next       = sweep_reg;
        sweep_reply_next = sweep_reply_reg;
        phase_b_next     = phase_b_reg;
        op_next          = op_reg;
        start_next       = start_reg;
        elem_b_next      = elem_b_reg;
        cur_next         = cur_reg;
        root_next        = root_reg;
        ra_next          = ra_reg;
        rb_next          = rb_reg;
        size_a_next      = size_a_reg;
        sz_next          = sz_reg;
        same_next        = same_reg;
        merged_next      = merged_reg;
        err_next         = err_reg;
        tbl_ctl          = '0;
        p_raddr          = cur_reg;
        p_waddr          = cur_reg;
        p_wdata          = root_reg;
        s_raddr          = ra_reg;
        s_waddr          = ra_reg;
        s_wdata          = sum;
        load_out         = 1'b0;

        unique case (state_reg)
            ST_SWEEP:
            begin
                tbl_ctl.parent_we = 1'b1;
                tbl_ctl.size_we   = 1'b1;
                p_waddr           = sweep_reg;
                p_wdata           = sweep_reg;
                s_waddr           = sweep_reg;
                s_wdata           = SIZE_W'(1);
                if (sweep_reg == LAST_IDX)
                begin
                    sweep_next       = '0;
                    sweep_reply_next = 1'b0;
                    state_next       = sweep_reply_reg ? ST_DONE : ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (acc)
                begin
                    op_next      = req.operation;
                    start_next   = IDX_W'(req.element_a);
                    elem_b_next  = IDX_W'(req.element_b);
                    phase_b_next = 1'b0;
                    ra_next      = '0;
                    rb_next      = '0;
                    sz_next      = '0;
                    same_next    = 1'b0;
                    merged_next  = 1'b0;
                    err_next     = 1'b0;
                    if (req.operation == OP_CLEAR)
                    begin
                        sweep_reply_next = 1'b1;
                        state_next       = ST_SWEEP;
                    end
                    else if ((req.operation == OP_FIND) || (req.operation == OP_SIZE))
                    begin
                        err_next   = a_bad;
                        state_next = a_bad ? ST_DONE : ST_WISSUE;
                    end
                    else if ((req.operation == OP_UNITE) || (req.operation == OP_SAME))
                    begin
                        err_next   = a_bad || b_bad;
                        state_next = (a_bad || b_bad) ? ST_DONE : ST_WISSUE;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            // Walk toward the root, one parent read per cycle.
            ST_WISSUE:
            begin
                p_raddr    = start_reg;
                cur_next   = start_reg;
                state_next = ST_WALK;
            end

            ST_WALK:
            begin
                if (eq)
                begin
                    root_next  = cur_reg;
                    state_next = ST_CISSUE;
                end
                else
                begin
                    cur_next = p_rdata;
                    p_raddr  = p_rdata;
                end
            end

            // Rewrite pass: point each node on the path at the root.
            ST_CISSUE:
            begin
                p_raddr    = start_reg;
                cur_next   = start_reg;
                state_next = ST_COMP;
            end

            ST_COMP:
            begin
                if (eq)
                begin
                    if (phase_b_reg)
                    begin
                        rb_next    = root_reg;
                        state_next = ST_SZA;
                    end
                    else
                    begin
                        ra_next = root_reg;
                        if (needs_b)
                        begin
                            phase_b_next = 1'b1;
                            start_next   = elem_b_reg;
                            state_next   = ST_WISSUE;
                        end
                        else
                        begin
                            state_next = ST_SZA;
                        end
                    end
                end
                else
                begin
                    tbl_ctl.parent_we = 1'b1;
                    p_waddr           = cur_reg;
                    p_wdata           = root_reg;
                    cur_next          = p_rdata;
                    p_raddr           = p_rdata;
                end
            end

            // Fetch both root sizes, then merge on a unite when the roots differ.
            ST_SZA:
            begin
                s_raddr    = ra_reg;
                state_next = ST_SZB;
            end

            ST_SZB:
            begin
                s_raddr     = rb_reg;
                size_a_next = s_rdata;
                state_next  = ST_SZC;
            end

            ST_SZC:
            begin
                sz_next = size_a_reg;
                if (needs_b)
                begin
                    same_next = eq;
                end
                if ((op_reg == OP_UNITE) && !eq)
                begin
                    tbl_ctl.parent_we = 1'b1;
                    tbl_ctl.size_we   = 1'b1;
                    p_waddr           = big_is_b ? ra_reg : rb_reg;
                    p_wdata           = big_is_b ? rb_reg : ra_reg;
                    s_waddr           = big_is_b ? rb_reg : ra_reg;
                    s_wdata           = sum;
                    ra_next           = big_is_b ? rb_reg : ra_reg;
                    sz_next           = sum;
                    merged_next       = 1'b1;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp_valid_next = (rsp_valid_reg && !rsp.ready) || load_out;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_SWEEP;
            sweep_reg       <= '0;
            sweep_reply_reg <= 1'b0;
            phase_b_reg     <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            sweep_reg       <= sweep_next;
            sweep_reply_reg <= sweep_reply_next;
            phase_b_reg     <= phase_b_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    // Working registers of the current operation.
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        start_reg  <= start_next;
        elem_b_reg <= elem_b_next;
        cur_reg    <= cur_next;
        root_reg   <= root_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        size_a_reg <= size_a_next;
        sz_reg     <= sz_next;
        same_reg   <= same_next;
        merged_reg <= merged_next;
        err_reg    <= err_next;
    end

    // Result register; holds a finished result while the next command runs.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            rsp_root_a_reg <= ELEM_W'(ra_reg);
            rsp_root_b_reg <= ELEM_W'(rb_reg);
            rsp_same_reg   <= same_reg;
            rsp_merged_reg <= merged_reg;
            rsp_size_reg   <= SIZE_OUT_W'(sz_reg);
            rsp_err_reg    <= err_reg;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.root_a      = rsp_root_a_reg;
    assign rsp.root_b      = rsp_root_b_reg;
    assign rsp.same_set    = rsp_same_reg;
    assign rsp.merged      = rsp_merged_reg;
    assign rsp.set_size    = rsp_size_reg;
    assign rsp.index_error = rsp_err_reg;

`ifndef NO_ASSERTIONS
    // A path rewrite never reads the entry it is writing.
    a_comp_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMP && tbl_ctl.parent_we) |-> (p_raddr != p_waddr))
        else $error("path rewrite reads the entry being written");

    // A clear command always starts a sweep.
    a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && req.operation == OP_CLEAR) |=> (state_reg == ST_SWEEP))
        else $error("clear did not start a sweep");

    // The tables are never written while waiting for a command.
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !(tbl_ctl.parent_we || tbl_ctl.size_we))
        else $error("table written while idle");

    // A merge never reports the two elements as already in one set.
    a_merge_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(rsp_same_reg && rsp_merged_reg))
        else $error("merged and same_set both set");

    // An index error carries no root or size.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_err_reg) |-> (rsp_root_a_reg == '0 && rsp_size_reg == '0))
        else $error("index error result carries data");
`endif

endmodule

`default_nettype wire

@@ hdl/disjoint_set_union_find_core.sv @@
// Find and set size walk and then rewrite the path of element_a to its root.
// Unite and same set do this for both elements, one parent read per walk or rewrite step.
// Clear runs a sweep that writes one entry of both tables per cycle.
// One command is in work at a time; a new one is taken while the last result waits.
// After reset the same sweep runs before the first command is taken;
// the element count resets to 512 and configuration writes are taken at any time.
`default_nettype none

module disjoint_set_union_find_core import dsu_pkg::*; #(
    parameter int MAX_ELEMENTS = 512
) (
    input  wire logic clk,
    input  wire logic rst_n,
    dsu_cfg_if.sink   cfg,
    dsu_in_if.sink    req,
    dsu_out_if.source rsp
);

    localparam int IDX_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int SIZE_W = $clog2(MAX_ELEMENTS + 1);

    logic [COUNT_W-1:0] element_count_reg;
    tbl_ctl_t           tbl_ctl;
    logic [IDX_W-1:0]   p_raddr;
    logic [IDX_W-1:0]   p_waddr;
    logic [IDX_W-1:0]   p_wdata;
    logic [IDX_W-1:0]   p_rdata;
    logic [IDX_W-1:0]   s_raddr;
    logic [IDX_W-1:0]   s_waddr;
    logic [SIZE_W-1:0]  s_wdata;
    logic [SIZE_W-1:0]  s_rdata;

    // Element count register; every write transfer is taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_count_reg <= COUNT_RESET;
        end
        else if (cfg.valid)
        begin
            element_count_reg <= cfg.data;
        end
    end

    // Sequencer with the shared compare unit and the result register.
    dsu_ctrl #(
        .DEPTH  (MAX_ELEMENTS),
        .IDX_W  (IDX_W),
        .SIZE_W (SIZE_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .rsp           (rsp),
        .element_count (element_count_reg),
        .tbl_ctl       (tbl_ctl),
        .p_raddr       (p_raddr),
        .p_waddr       (p_waddr),
        .p_wdata       (p_wdata),
        .p_rdata       (p_rdata),
        .s_raddr       (s_raddr),
        .s_waddr       (s_waddr),
        .s_wdata       (s_wdata),
        .s_rdata       (s_rdata)
    );

    // Parent and size memories.
    dsu_table #(
        .DEPTH  (MAX_ELEMENTS),
        .IDX_W  (IDX_W),
        .SIZE_W (SIZE_W)
    ) u_table (
        .clk     (clk),
        .tbl_ctl (tbl_ctl),
        .p_raddr (p_raddr),
        .p_waddr (p_waddr),
        .p_wdata (p_wdata),
        .p_rdata (p_rdata),
        .s_raddr (s_raddr),
        .s_waddr (s_waddr),
        .s_wdata (s_wdata),
        .s_rdata (s_rdata)
    );

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`default_nettype none

module tb_top;
    import dsu_pkg::*;

    localparam int TBL_DEPTH   = 512;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_AT_CMD = 150;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_GUARD = 64;
    localparam int MAX_REPORTS = 50;

    // Operation codes the block must ignore.
    localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ELEM_W-1:0] a;
        logic [ELEM_W-1:0] b;
    } dsu_cmd_t;

    typedef struct packed {
        logic [ELEM_W-1:0]     root_a;
        logic [ELEM_W-1:0]     root_b;
        logic                  same_set;
        logic                  merged;
        logic [SIZE_OUT_W-1:0] set_size;
        logic                  index_error;
    } dsu_result_t;

    typedef struct {
        int          seq;
        dsu_cmd_t    cmd;
        dsu_result_t res;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Values driven onto the channels; each has a single owning process.
    logic               cmd_valid = 1'b0;
    logic [OP_W-1:0]    cmd_op    = '0;
    logic [ELEM_W-1:0]  cmd_a     = '0;
    logic [ELEM_W-1:0]  cmd_b     = '0;
    logic               res_ready = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [COUNT_W-1:0] cfg_data  = '0;

    dsu_cfg_if cfg_bus ();
    dsu_in_if  cmd_bus ();
    dsu_out_if res_bus ();

    assign cfg_bus.valid     = cfg_valid;
    assign cfg_bus.data      = cfg_data;
    assign cmd_bus.valid     = cmd_valid;
    assign cmd_bus.operation = cmd_op;
    assign cmd_bus.element_a = cmd_a;
    assign cmd_bus.element_b = cmd_b;
    assign res_bus.ready     = res_ready;

    disjoint_set_union_find_core #(
        .MAX_ELEMENTS(TBL_DEPTH)
    ) u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg_bus),
        .req  (cmd_bus),
        .rsp  (res_bus)
    );

    // Shadow copy of the tables and the element count.
    logic [ELEM_W-1:0]  shadow_parent [TBL_DEPTH];
    logic [COUNT_W-1:0] shadow_size   [TBL_DEPTH];
    logic [COUNT_W-1:0] shadow_count;

    dsu_cmd_t cmd_backlog [$];
    outcome_t outcome_queue [$];

    int  cmds_issued   = 0;
    int  cmds_accepted = 0;
    int  results_seen  = 0;
    int  error_count   = 0;
    int  cycle_count   = 0;
    int  merges_seen   = 0;
    int  range_errors  = 0;
    int  clears_seen   = 0;
    int  biggest_set   = 0;
    int  counts_used   = 0;
    int  hold_left     = 0;
    bit  hold_done     = 1'b0;
    int  send_wait     = 0;
    int  recv_wait     = 0;
    bit  send_burst    = 1'b0;
    bit  recv_burst    = 1'b0;
    bit  cmd_fire;
    dsu_cmd_t    cmd_cur;
    dsu_result_t res_got;
    outcome_t    res_pred;
    outcome_t    res_want;

    function automatic void clear_shadow();
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            shadow_parent[i] = ELEM_W'(i);
            shadow_size[i]   = COUNT_W'(1);
        end
    endfunction

    // Walk to the root, then point every node on the path straight at it.
    function automatic logic [ELEM_W-1:0] find_root_compress(logic [ELEM_W-1:0] x);
        logic [ELEM_W-1:0] r;
        logic [ELEM_W-1:0] cur;
        logic [ELEM_W-1:0] nxt;
        int                steps;
        r = x;
        steps = 0;
        while (shadow_parent[r] != r && steps < TBL_DEPTH)
        begin
            r = shadow_parent[r];
            steps++;
        end
        cur = x;
        steps = 0;
        while (cur != r && steps < TBL_DEPTH)
        begin
            nxt = shadow_parent[cur];
            shadow_parent[cur] = r;
            cur = nxt;
            steps++;
        end
        return r;
    endfunction

    // Apply one command to the shadow tables and return the result it must produce.
    function automatic dsu_result_t apply_command(dsu_cmd_t c);
        dsu_result_t       res;
        int                live;
        logic [ELEM_W-1:0] big;
        logic [ELEM_W-1:0] little;
        res  = '0;
        live = (shadow_count > TBL_DEPTH) ? TBL_DEPTH : int'(shadow_count);
        case (c.op)
            OP_CLEAR:
            begin
                clear_shadow();
                clears_seen++;
            end
            OP_FIND, OP_SIZE:
            begin
                if (int'(c.a) >= live)
                    res.index_error = 1'b1;
                else
                begin
                    res.root_a   = find_root_compress(c.a);
                    res.set_size = shadow_size[res.root_a];
                end
            end
            OP_UNITE, OP_SAME:
            begin
                if (int'(c.a) >= live || int'(c.b) >= live)
                    res.index_error = 1'b1;
                else
                begin
                    res.root_a   = find_root_compress(c.a);
                    res.root_b   = find_root_compress(c.b);
                    res.same_set = (res.root_a == res.root_b);
                    if (c.op == OP_UNITE && !res.same_set)
                    begin
                        // Union by size; the root of element_a wins a tie.
                        big    = res.root_a;
                        little = res.root_b;
                        if (shadow_size[res.root_a] < shadow_size[res.root_b])
                        begin
                            big    = res.root_b;
                            little = res.root_a;
                        end
                        shadow_parent[little] = big;
                        shadow_size[big]      = shadow_size[big] + shadow_size[little];
                        res.merged = 1'b1;
                        res.root_a = big;
                        merges_seen++;
                    end
                    res.set_size = shadow_size[res.root_a];
                end
            end
            default:
            begin
            end
        endcase
        if (res.index_error)
            range_errors++;
        if (int'(res.set_size) > biggest_set)
            biggest_set = int'(res.set_size);
        return res;
    endfunction

    // Wait length for the next item; occasionally switch into or out of a burst stretch.
    function automatic int draw_gap(inout bit burst);
        if ($urandom_range(0, 19) == 0)
            burst = !burst;
        return burst ? 0 : int'($urandom_range(0, 6));
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR at cycle %0d: %s", cycle_count, what);
    endtask

    task automatic queue_cmd(input logic [OP_W-1:0] op, input int a, input int b);
        dsu_cmd_t c;
        c.op = op;
        c.a  = ELEM_W'(a);
        c.b  = ELEM_W'(b);
        cmd_backlog = {cmd_backlog, c};
        cmds_issued++;
    endtask

    task automatic program_count(input logic [COUNT_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_bus.ready));
        cfg_valid <= 1'b0;
        shadow_count = value;
        counts_used++;
    endtask

    task automatic wait_drained();
        while (cmds_accepted != cmds_issued || outcome_queue.size() != 0)
            @(posedge clk);
    endtask

    // Random commands, mostly on indices in range so that the trees grow deep.
    task automatic run_random_phase(input logic [COUNT_W-1:0] count, input int n);
        int              live;
        int              pick;
        int              a;
        int              b;
        logic [OP_W-1:0] op;
        program_count(count);
        live = (count > TBL_DEPTH) ? TBL_DEPTH : int'(count);
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 2)
                op = OP_CLEAR;
            else if (pick < 3)
                op = OP_RSVD5;
            else if (pick < 4)
                op = OP_RSVD6;
            else if (pick < 5)
                op = OP_RSVD7;
            else if (pick < 40)
                op = OP_UNITE;
            else if (pick < 60)
                op = OP_FIND;
            else if (pick < 80)
                op = OP_SAME;
            else
                op = OP_SIZE;
            if (live == 0 || $urandom_range(0, 9) == 0)
                a = $urandom_range(0, TBL_DEPTH - 1);
            else
                a = $urandom_range(0, live - 1);
            if (live == 0 || $urandom_range(0, 9) == 0)
                b = $urandom_range(0, TBL_DEPTH - 1);
            else
                b = $urandom_range(0, live - 1);
            queue_cmd(op, a, b);
        end
        wait_drained();
    endtask

    // Clock.
    initial
    begin
        forever #4 clk = ~clk;
    end

    // Command driver: present backlog items, predict each one at its transfer.
    always @(posedge clk)
    begin
        cmd_fire = cmd_valid && cmd_bus.ready;
        if (cmd_fire)
        begin
            res_pred.seq = cmds_accepted;
            res_pred.cmd = cmd_cur;
            res_pred.res = apply_command(cmd_cur);
            outcome_queue = {outcome_queue, res_pred};
            cmds_accepted <= cmds_accepted + 1;
            send_wait = draw_gap(send_burst);
        end
        if (!cmd_valid || cmd_fire)
        begin
            if (send_wait != 0)
            begin
                send_wait--;
                cmd_valid <= 1'b0;
            end
            else if (cmd_backlog.size() != 0)
            begin
                cmd_cur = cmd_backlog.pop_front();
                cmd_valid <= 1'b1;
                cmd_op    <= cmd_cur.op;
                cmd_a     <= cmd_cur.a;
                cmd_b     <= cmd_cur.b;
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // One long receiver hold-off while commands keep coming.
    always @(posedge clk)
    begin
        if (!hold_done && cmds_accepted == HOLD_AT_CMD)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Result monitor: check each transfer against the oldest expectation.
    always @(posedge clk)
    begin
        if (res_ready && res_bus.valid)
        begin
            res_got.root_a      = res_bus.root_a;
            res_got.root_b      = res_bus.root_b;
            res_got.same_set    = res_bus.same_set;
            res_got.merged      = res_bus.merged;
            res_got.set_size    = res_bus.set_size;
            res_got.index_error = res_bus.index_error;
            if (outcome_queue.size() == 0)
                report_mismatch($sformatf("result with nothing expected: ra=%0d rb=%0d sz=%0d",
                                          res_got.root_a, res_got.root_b, res_got.set_size));
            else
            begin
                res_want = outcome_queue.pop_front();
                if (res_got.root_a !== res_want.res.root_a
                    || res_got.root_b !== res_want.res.root_b
                    || res_got.same_set !== res_want.res.same_set
                    || res_got.merged !== res_want.res.merged
                    || res_got.set_size !== res_want.res.set_size
                    || res_got.index_error !== res_want.res.index_error)
                    report_mismatch($sformatf(
                        "cmd %0d op=%0d a=%0d b=%0d got %0d/%0d/%0b/%0b/%0d/%0b want %0d/%0d/%0b/%0b/%0d/%0b",
                        res_want.seq, res_want.cmd.op, res_want.cmd.a, res_want.cmd.b,
                        res_got.root_a, res_got.root_b, res_got.same_set, res_got.merged,
                        res_got.set_size, res_got.index_error,
                        res_want.res.root_a, res_want.res.root_b, res_want.res.same_set,
                        res_want.res.merged, res_want.res.set_size, res_want.res.index_error));
            end
            results_seen++;
            recv_wait = draw_gap(recv_burst);
        end
        if (hold_left != 0)
            res_ready <= 1'b0;
        else if (recv_wait != 0)
        begin
            recv_wait--;
            res_ready <= 1'b0;
        end
        else
            res_ready <= 1'b1;
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, outcome_queue.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        clear_shadow();
        shadow_count = COUNT_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Full table: every operation, tie and size ordering in unite, ignored codes.
        program_count(COUNT_RESET);
        queue_cmd(OP_FIND, 0, 0);
        queue_cmd(OP_FIND, 511, 511);
        queue_cmd(OP_UNITE, 0, 511);
        queue_cmd(OP_UNITE, 511, 0);
        queue_cmd(OP_SAME, 1, 2);
        queue_cmd(OP_UNITE, 1, 2);
        queue_cmd(OP_UNITE, 2, 0);
        queue_cmd(OP_UNITE, 3, 0);
        queue_cmd(OP_SIZE, 3, 0);
        queue_cmd(OP_RSVD5, 0, 511);
        queue_cmd(OP_RSVD6, 511, 0);
        queue_cmd(OP_RSVD7, 511, 511);
        queue_cmd(OP_CLEAR, 511, 511);
        queue_cmd(OP_UNITE, 500, 0);
        queue_cmd(OP_SIZE, 511, 0);
        queue_cmd(OP_FIND, 0, 0);
        wait_drained();

        // Lowered count: a valid element keeps a root beyond the count.
        program_count(10'd3);
        queue_cmd(OP_FIND, 0, 0);
        queue_cmd(OP_UNITE, 2, 3);
        queue_cmd(OP_SAME, 3, 1);
        queue_cmd(OP_SIZE, 2, 0);
        wait_drained();

        // Zero count turns every indexed operation into an index error.
        program_count(10'd0);
        queue_cmd(OP_FIND, 0, 0);
        queue_cmd(OP_CLEAR, 0, 0);
        wait_drained();

        // Oversized count acts as the full table.
        program_count(10'd1023);
        queue_cmd(OP_FIND, 511, 0);
        queue_cmd(OP_UNITE, 511, 510);
        wait_drained();

        run_random_phase(COUNT_RESET, 280);
        run_random_phase(10'd16, 200);
        run_random_phase(10'd1, 30);
        run_random_phase(10'd1023, 150);
        run_random_phase(10'd100, 150);
        run_random_phase(10'd0, 20);
        run_random_phase(COUNT_W'($urandom_range(1, TBL_DEPTH)), 60);
        run_random_phase(10'd2, 40);

        repeat (DRAIN_GUARD) @(posedge clk);
        if (outcome_queue.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      outcome_queue.size()));

        $display("Ran %0d commands over %0d element-count settings, %0d results checked.",
                 cmds_accepted, counts_used, results_seen);
        $display("Saw %0d merges, %0d index errors, %0d clears, largest set %0d.",
                 merges_seen, range_errors, clears_seen, biggest_set);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
